// ===== hw/rtl/bpp_pkg.sv =====
package bpp_pkg;

    // quotient bits are retired two per divider stage
    localparam int DIV_STAGES = 16;
    localparam int DIV_LAT    = DIV_STAGES + 2;
    localparam int PUSH_LAT   = 2 * DIV_LAT + 16;

    localparam logic [3:0] CFG_MODE   = 4'd0;
    localparam logic [3:0] CFG_DT     = 4'd1;
    localparam logic [3:0] CFG_B0     = 4'd2;
    localparam logic [3:0] CFG_BX     = 4'd3;
    localparam logic [3:0] CFG_BZ     = 4'd4;
    localparam logic [3:0] CFG_EY     = 4'd5;
    localparam logic [3:0] CFG_RATIO  = 4'd6;
    localparam logic [3:0] CFG_DOMAIN = 4'd7;

    localparam logic signed [65:0] QMAX66 = 66'sd2147483647;
    localparam logic signed [65:0] QMIN66 = -66'sd2147483648;

    function automatic logic signed [31:0] sat32(input logic signed [65:0] x);
        if (x > QMAX66)
            return 32'sh7FFF_FFFF;
        if (x < QMIN66)
            return 32'sh8000_0000;
        return $signed(x[31:0]);
    endfunction

    function automatic logic signed [31:0] add_sat(input logic signed [31:0] a,
                                                   input logic signed [31:0] b);
        logic signed [65:0] s;
        s = 66'(a) + 66'(b);
        return sat32(s);
    endfunction

    function automatic logic signed [31:0] sub_sat(input logic signed [31:0] a,
                                                   input logic signed [31:0] b);
        logic signed [65:0] s;
        s = 66'(a) - 66'(b);
        return sat32(s);
    endfunction

    function automatic logic signed [31:0] neg_sat(input logic signed [31:0] a);
        return sub_sat(32'sd0, a);
    endfunction

endpackage

// ===== hw/rtl/bpp_delay.sv =====
module bpp_delay #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1
) (
    input  logic             clk,
    input  logic [WIDTH-1:0] d,
    output logic [WIDTH-1:0] q
);

    logic [WIDTH-1:0] tap_reg [0:DEPTH-1];

    always_ff @(posedge clk)
    begin
        tap_reg[0] <= d;
        for (int i = 1; i < DEPTH; i++)
        begin
            tap_reg[i] <= tap_reg[i-1];
        end
    end

    assign q = tap_reg[DEPTH-1];

endmodule

// ===== hw/rtl/bpp_div.sv =====
module bpp_div
    import bpp_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic               clk,
    input  logic signed [32:0] num,
    input  logic        [30:0] den,
    output logic signed [31:0] quo
);

    localparam int NW = 33 + FRAC_BITS;

    logic [32:0]   mag;
    logic [NW-1:0] dvd;
    logic          ovf;

    logic [31:0] rem_reg [0:DIV_STAGES];
    logic [31:0] low_reg [0:DIV_STAGES];
    logic [31:0] quo_reg [0:DIV_STAGES];
    logic [30:0] den_reg [0:DIV_STAGES];
    logic        neg_reg [0:DIV_STAGES];
    logic        ovf_reg [0:DIV_STAGES];

    function automatic logic [32:0] div_step(input logic [31:0] r, input logic b,
                                             input logic [30:0] d);
        logic [32:0] t;
        t = {r, b};
        if (t >= 33'(d))
            return {1'b1, 32'(t - 33'(d))};
        return {1'b0, t[31:0]};
    endfunction

    // quotient of 2^32 or more can only saturate
    always_comb
    begin
        mag = num[32] ? 33'(-num) : 33'(num);
        dvd = {mag, {FRAC_BITS{1'b0}}};
        ovf = (mag != '0) && (64'(dvd) >= {1'b0, den, 32'b0});
    end

    // a zero divisor saturates through ovf, or divides zero to zero
    always_ff @(posedge clk)
    begin
        rem_reg[0] <= 32'(dvd >> 32);
        low_reg[0] <= dvd[31:0];
        quo_reg[0] <= '0;
        den_reg[0] <= (den == '0) ? 31'd1 : den;
        neg_reg[0] <= num[32];
        ovf_reg[0] <= ovf;
    end

    for (genvar k = 1; k <= DIV_STAGES; k++)
    begin : g_stage
        logic [32:0] step_a;
        logic [32:0] step_b;

        always_comb
        begin
            step_a = div_step(rem_reg[k-1], low_reg[k-1][31], den_reg[k-1]);
            step_b = div_step(step_a[31:0], low_reg[k-1][30], den_reg[k-1]);
        end

        always_ff @(posedge clk)
        begin
            rem_reg[k] <= step_b[31:0];
            low_reg[k] <= {low_reg[k-1][29:0], 2'b00};
            quo_reg[k] <= {quo_reg[k-1][29:0], step_a[32], step_b[32]};
            den_reg[k] <= den_reg[k-1];
            neg_reg[k] <= neg_reg[k-1];
            ovf_reg[k] <= ovf_reg[k-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (neg_reg[DIV_STAGES])
        begin
            if (ovf_reg[DIV_STAGES] || (quo_reg[DIV_STAGES] > 32'h8000_0000))
                quo <= 32'sh8000_0000;
            else
                quo <= $signed(-quo_reg[DIV_STAGES]);
        end
        else
        begin
            if (ovf_reg[DIV_STAGES] || quo_reg[DIV_STAGES][31])
                quo <= 32'sh7FFF_FFFF;
            else
                quo <= $signed(quo_reg[DIV_STAGES]);
        end
    end

endmodule

// ===== hw/rtl/boris_particle_push_core.sv =====
// channel   direction  handshake                 payload
// request   in         start high, busy low      pos_*, vel_*, charge, mass, coulomb_f*
// result    out        done strobe, one cycle    new_pos_*, new_vel_*, kinetic_energy
// config    in         cfg_wr_en                 cfg_index, cfg_wdata
//
// one particle per clock; busy stays low, a request may arrive every cycle
// each result passes two 16-stage radix-4 dividers in series on its way to done
// (q/m, F/m and 2z/L first, then 2t/(1+t^2))
// rst_n clears the valid pipe and loads the register defaults
// the receiver takes every result as it is strobed, nothing ever waits
module boris_particle_push_core
    import bpp_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               cfg_wr_en,
    input  logic        [3:0]  cfg_index,
    input  logic        [31:0] cfg_wdata,
    input  logic signed [31:0] pos_x,
    input  logic signed [31:0] pos_y,
    input  logic signed [31:0] pos_z,
    input  logic signed [31:0] vel_x,
    input  logic signed [31:0] vel_y,
    input  logic signed [31:0] vel_z,
    input  logic signed [31:0] charge,
    input  logic        [30:0] mass,
    input  logic signed [31:0] coulomb_fx,
    input  logic signed [31:0] coulomb_fy,
    input  logic signed [31:0] coulomb_fz,
    output logic               done,
    output logic signed [31:0] new_pos_x,
    output logic signed [31:0] new_pos_y,
    output logic signed [31:0] new_pos_z,
    output logic signed [31:0] new_vel_x,
    output logic signed [31:0] new_vel_y,
    output logic signed [31:0] new_vel_z,
    output logic        [31:0] kinetic_energy
);

    localparam logic signed [31:0] ONE = 32'(64'd1 << FRAC_BITS);
    localparam int POS_DLY  = 2 * DIV_LAT + 10;
    localparam int VEL_DLY  = DIV_LAT + 3;
    localparam int MASS_DLY = 2 * DIV_LAT + 14;

    function automatic logic signed [31:0] qfix(input logic signed [63:0] p);
        return sat32(66'(p >>> FRAC_BITS));
    endfunction

    // configuration
    logic        [1:0]  mode_reg;
    logic        [30:0] dt_reg;
    logic signed [31:0] b0_reg;
    logic signed [31:0] bx_reg;
    logic signed [31:0] bz_reg;
    logic signed [31:0] ey_reg;
    logic        [30:0] ratio_reg;
    logic        [30:0] len_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= 2'd0;
            dt_reg    <= 31'd655;
            b0_reg    <= 32'sd65536;
            bx_reg    <= 32'sd0;
            bz_reg    <= 32'sd65536;
            ey_reg    <= 32'sd0;
            ratio_reg <= 31'd196608;
            len_reg   <= 31'd655360;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_MODE:   mode_reg  <= cfg_wdata[1:0];
                CFG_DT:     dt_reg    <= cfg_wdata[30:0];
                CFG_B0:     b0_reg    <= $signed(cfg_wdata);
                CFG_BX:     bx_reg    <= $signed(cfg_wdata);
                CFG_BZ:     bz_reg    <= $signed(cfg_wdata);
                CFG_EY:     ey_reg    <= $signed(cfg_wdata);
                CFG_RATIO:  ratio_reg <= cfg_wdata[30:0];
                CFG_DOMAIN: len_reg   <= cfg_wdata[30:0];
                default:    ;
            endcase
        end
    end

    logic signed [31:0] dt_s;
    logic signed [31:0] len_s;
    logic signed [31:0] ratio_m1;
    logic               mirror;
    logic               periodic;

    assign dt_s     = $signed({1'b0, dt_reg});
    assign len_s    = $signed({1'b0, len_reg});
    assign ratio_m1 = $signed({1'b0, ratio_reg}) - ONE;
    assign mirror   = mode_reg[0];
    assign periodic = mode_reg[1];

    // valid pipe
    logic [PUSH_LAT:0] vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= {vld_reg[PUSH_LAT-1:0], start & ~busy};
    end

    assign busy = 1'b0;
    assign done = vld_reg[PUSH_LAT];

    // stage 0: capture request
    logic signed [31:0] pos0_reg [0:2];
    logic signed [31:0] vel0_reg [0:2];
    logic signed [31:0] frc0_reg [0:2];
    logic signed [31:0] chg0_reg;
    logic        [30:0] mass0_reg;

    always_ff @(posedge clk)
    begin
        pos0_reg[0] <= pos_x;
        pos0_reg[1] <= pos_y;
        pos0_reg[2] <= pos_z;
        vel0_reg[0] <= vel_x;
        vel0_reg[1] <= vel_y;
        vel0_reg[2] <= vel_z;
        frc0_reg[0] <= coulomb_fx;
        frc0_reg[1] <= coulomb_fy;
        frc0_reg[2] <= coulomb_fz;
        chg0_reg    <= charge;
        mass0_reg   <= mass;
    end

    logic [95:0] pos_dly;
    logic [95:0] vel_dly;
    logic [30:0] mass_dly;

    bpp_delay #(.WIDTH(96), .DEPTH(POS_DLY)) u_pos_dly (
        .clk (clk),
        .d   ({pos0_reg[0], pos0_reg[1], pos0_reg[2]}),
        .q   (pos_dly)
    );

    bpp_delay #(.WIDTH(96), .DEPTH(VEL_DLY)) u_vel_dly (
        .clk (clk),
        .d   ({vel0_reg[0], vel0_reg[1], vel0_reg[2]}),
        .q   (vel_dly)
    );

    bpp_delay #(.WIDTH(31), .DEPTH(MASS_DLY)) u_mass_dly (
        .clk (clk),
        .d   (mass0_reg),
        .q   (mass_dly)
    );

    // first dividers: q/m, F/m, 2z/L
    logic signed [31:0] qm_q;
    logic signed [31:0] fm_q [0:2];
    logic signed [31:0] zn_q;

    bpp_div #(.FRAC_BITS(FRAC_BITS)) u_div_qm (
        .clk (clk),
        .num (33'(chg0_reg)),
        .den (mass0_reg),
        .quo (qm_q)
    );

    for (genvar i = 0; i < 3; i++)
    begin : g_div_f
        bpp_div #(.FRAC_BITS(FRAC_BITS)) u_div_fm (
            .clk (clk),
            .num (33'(frc0_reg[i])),
            .den (mass0_reg),
            .quo (fm_q[i])
        );
    end

    bpp_div #(.FRAC_BITS(FRAC_BITS)) u_div_zn (
        .clk (clk),
        .num ($signed({pos0_reg[2], 1'b0})),
        .den (len_reg),
        .quo (zn_q)
    );

    // stage 2
    logic signed [63:0] pqd2_reg;
    logic signed [63:0] pfd2_reg [0:2];
    logic signed [63:0] pa2_reg;
    logic signed [31:0] zn2_reg;

    always_ff @(posedge clk)
    begin
        pqd2_reg <= qm_q * dt_s;
        for (int i = 0; i < 3; i++)
        begin
            pfd2_reg[i] <= fm_q[i] * dt_s;
        end
        pa2_reg <= ratio_m1 * zn_q;
        zn2_reg <= zn_q;
    end

    // stage 3
    logic signed [31:0] qmdt3_next;
    logic signed [31:0] a3_next;
    logic signed [31:0] qmdt3_reg;
    logic signed [31:0] kf3_reg [0:2];
    logic signed [63:0] pe3_reg;
    logic signed [63:0] pb3_reg;

    assign qmdt3_next = qfix(pqd2_reg) >>> 1;
    assign a3_next    = qfix(pa2_reg);

    always_ff @(posedge clk)
    begin
        qmdt3_reg <= qmdt3_next;
        for (int i = 0; i < 3; i++)
        begin
            kf3_reg[i] <= qfix(pfd2_reg[i]) >>> 1;
        end
        pe3_reg <= qmdt3_next * ey_reg;
        pb3_reg <= a3_next * zn2_reg;
    end

    // stage 4
    logic signed [31:0] qmdt4_reg;
    logic signed [31:0] kf4_reg [0:2];
    logic signed [31:0] e4_reg;
    logic signed [31:0] mf4_reg;

    always_ff @(posedge clk)
    begin
        qmdt4_reg <= qmdt3_reg;
        kf4_reg   <= kf3_reg;
        e4_reg    <= qfix(pe3_reg);
        mf4_reg   <= add_sat(ONE, qfix(pb3_reg));
    end

    // stage 5: kicks and v-minus
    logic signed [31:0] kick5_next [0:2];
    logic signed [31:0] qmdt5_reg;
    logic signed [31:0] kick5_reg [0:2];
    logic signed [31:0] vm5_reg [0:2];
    logic signed [63:0] pbz5_reg;

    always_comb
    begin
        kick5_next[0] = kf4_reg[0];
        kick5_next[1] = add_sat(e4_reg, kf4_reg[1]);
        kick5_next[2] = kf4_reg[2];
    end

    always_ff @(posedge clk)
    begin
        qmdt5_reg  <= qmdt4_reg;
        kick5_reg  <= kick5_next;
        vm5_reg[0] <= add_sat($signed(vel_dly[95:64]), kick5_next[0]);
        vm5_reg[1] <= add_sat($signed(vel_dly[63:32]), kick5_next[1]);
        vm5_reg[2] <= add_sat($signed(vel_dly[31:0]), kick5_next[2]);
        pbz5_reg   <= b0_reg * mf4_reg;
    end

    // stage 6: t = qmdt * B, y component is always zero
    logic signed [31:0] bz6_next;
    logic signed [63:0] pt0_6_reg;
    logic signed [63:0] pt2_6_reg;
    logic signed [31:0] vm6_reg [0:2];
    logic signed [31:0] kick6_reg [0:2];

    assign bz6_next = qfix(pbz5_reg);

    always_ff @(posedge clk)
    begin
        pt0_6_reg <= qmdt5_reg * (mirror ? 32'sd0 : bx_reg);
        pt2_6_reg <= qmdt5_reg * (mirror ? bz6_next : bz_reg);
        vm6_reg   <= vm5_reg;
        kick6_reg <= kick5_reg;
    end

    // stage 7
    logic signed [31:0] t0_7_next;
    logic signed [31:0] t2_7_next;
    logic signed [31:0] t0_7_reg;
    logic signed [31:0] t2_7_reg;
    logic signed [63:0] ptt0_7_reg;
    logic signed [63:0] ptt2_7_reg;
    logic signed [63:0] pc7_reg [0:3];
    logic signed [31:0] vm7_reg [0:2];
    logic signed [31:0] kick7_reg [0:2];

    assign t0_7_next = qfix(pt0_6_reg);
    assign t2_7_next = qfix(pt2_6_reg);

    always_ff @(posedge clk)
    begin
        t0_7_reg   <= t0_7_next;
        t2_7_reg   <= t2_7_next;
        ptt0_7_reg <= t0_7_next * t0_7_next;
        ptt2_7_reg <= t2_7_next * t2_7_next;
        pc7_reg[0] <= vm6_reg[1] * t2_7_next;
        pc7_reg[1] <= vm6_reg[2] * t0_7_next;
        pc7_reg[2] <= vm6_reg[0] * t2_7_next;
        pc7_reg[3] <= vm6_reg[1] * t0_7_next;
        vm7_reg    <= vm6_reg;
        kick7_reg  <= kick6_reg;
    end

    // stage 8: v-plus and 1 + |t|^2
    logic signed [65:0] tsum8_next;
    logic signed [31:0] den8_next;
    logic        [30:0] den8_reg;
    logic signed [32:0] n0_8_reg;
    logic signed [32:0] n2_8_reg;
    logic signed [31:0] vp8_reg [0:2];
    logic signed [31:0] vm8_reg [0:2];
    logic signed [31:0] kick8_reg [0:2];

    assign tsum8_next = 66'(qfix(ptt0_7_reg)) + 66'(qfix(ptt2_7_reg)) + 66'(ONE);
    assign den8_next  = sat32(tsum8_next);

    always_ff @(posedge clk)
    begin
        den8_reg   <= den8_next[30:0];
        n0_8_reg   <= $signed({t0_7_reg, 1'b0});
        n2_8_reg   <= $signed({t2_7_reg, 1'b0});
        vp8_reg[0] <= add_sat(vm7_reg[0], qfix(pc7_reg[0]));
        vp8_reg[1] <= add_sat(vm7_reg[1], sub_sat(qfix(pc7_reg[1]), qfix(pc7_reg[2])));
        vp8_reg[2] <= add_sat(vm7_reg[2], neg_sat(qfix(pc7_reg[3])));
        vm8_reg    <= vm7_reg;
        kick8_reg  <= kick7_reg;
    end

    // second dividers: s = 2t / (1 + |t|^2)
    logic signed [31:0] s0_q;
    logic signed [31:0] s2_q;
    logic        [287:0] mid_dly;

    bpp_div #(.FRAC_BITS(FRAC_BITS)) u_div_s0 (
        .clk (clk),
        .num (n0_8_reg),
        .den (den8_reg),
        .quo (s0_q)
    );

    bpp_div #(.FRAC_BITS(FRAC_BITS)) u_div_s2 (
        .clk (clk),
        .num (n2_8_reg),
        .den (den8_reg),
        .quo (s2_q)
    );

    bpp_delay #(.WIDTH(288), .DEPTH(DIV_LAT)) u_mid_dly (
        .clk (clk),
        .d   ({vp8_reg[0], vp8_reg[1], vp8_reg[2],
               vm8_reg[0], vm8_reg[1], vm8_reg[2],
               kick8_reg[0], kick8_reg[1], kick8_reg[2]}),
        .q   (mid_dly)
    );

    logic signed [31:0] vp9 [0:2];
    logic signed [31:0] vm9 [0:2];
    logic signed [31:0] kick9 [0:2];

    always_comb
    begin
        vp9[0]   = $signed(mid_dly[287:256]);
        vp9[1]   = $signed(mid_dly[255:224]);
        vp9[2]   = $signed(mid_dly[223:192]);
        vm9[0]   = $signed(mid_dly[191:160]);
        vm9[1]   = $signed(mid_dly[159:128]);
        vm9[2]   = $signed(mid_dly[127:96]);
        kick9[0] = $signed(mid_dly[95:64]);
        kick9[1] = $signed(mid_dly[63:32]);
        kick9[2] = $signed(mid_dly[31:0]);
    end

    // stage 10
    logic signed [63:0] pe10_reg [0:3];
    logic signed [31:0] vm10_reg [0:2];
    logic signed [31:0] kick10_reg [0:2];

    always_ff @(posedge clk)
    begin
        pe10_reg[0] <= vp9[1] * s2_q;
        pe10_reg[1] <= vp9[2] * s0_q;
        pe10_reg[2] <= vp9[0] * s2_q;
        pe10_reg[3] <= vp9[1] * s0_q;
        vm10_reg    <= vm9;
        kick10_reg  <= kick9;
    end

    // stage 11
    logic signed [31:0] vr11_reg [0:2];
    logic signed [31:0] kick11_reg [0:2];

    always_ff @(posedge clk)
    begin
        vr11_reg[0] <= add_sat(vm10_reg[0], qfix(pe10_reg[0]));
        vr11_reg[1] <= add_sat(vm10_reg[1], sub_sat(qfix(pe10_reg[1]), qfix(pe10_reg[2])));
        vr11_reg[2] <= add_sat(vm10_reg[2], neg_sat(qfix(pe10_reg[3])));
        kick11_reg  <= kick10_reg;
    end

    // stage 12: second half kick, v * dt
    logic signed [31:0] vn12_next [0:2];
    logic signed [31:0] vn12_reg [0:2];
    logic signed [63:0] ppd12_reg [0:2];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            vn12_next[i] = add_sat(vr11_reg[i], kick11_reg[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        vn12_reg <= vn12_next;
        for (int i = 0; i < 3; i++)
        begin
            ppd12_reg[i] <= vn12_next[i] * dt_s;
        end
    end

    // stage 13
    logic signed [31:0] pn13_reg [0:2];
    logic signed [31:0] vn13_reg [0:2];

    always_ff @(posedge clk)
    begin
        pn13_reg[0] <= add_sat($signed(pos_dly[95:64]), qfix(ppd12_reg[0]));
        pn13_reg[1] <= add_sat($signed(pos_dly[63:32]), qfix(ppd12_reg[1]));
        pn13_reg[2] <= add_sat($signed(pos_dly[31:0]), qfix(ppd12_reg[2]));
        vn13_reg    <= vn12_reg;
    end

    // stage 14: boundary rule per axis
    logic signed [31:0] half_s;
    logic signed [31:0] nhalf_s;
    logic signed [31:0] pb14_next [0:2];
    logic signed [31:0] vb14_next [0:2];
    logic signed [31:0] pb14_reg [0:2];
    logic signed [31:0] vb14_reg [0:2];

    assign half_s  = $signed({2'b00, len_reg[30:1]});
    assign nhalf_s = -half_s;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            pb14_next[i] = pn13_reg[i];
            vb14_next[i] = vn13_reg[i];
            if (periodic)
            begin
                if (pb14_next[i] > half_s)
                    pb14_next[i] = sub_sat(pb14_next[i], len_s);
                if (pb14_next[i] < nhalf_s)
                    pb14_next[i] = add_sat(pb14_next[i], len_s);
            end
            else
            begin
                if (pb14_next[i] > half_s)
                begin
                    pb14_next[i] = half_s;
                    vb14_next[i] = neg_sat(vb14_next[i]);
                end
                if (pb14_next[i] < nhalf_s)
                begin
                    pb14_next[i] = nhalf_s;
                    vb14_next[i] = neg_sat(vb14_next[i]);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pb14_reg <= pb14_next;
        vb14_reg <= vb14_next;
    end

    // stages 15 to 17: kinetic energy
    logic signed [63:0] psq15_reg [0:2];
    logic signed [31:0] pb15_reg [0:2];
    logic signed [31:0] vb15_reg [0:2];
    logic        [63:0] v2_16_reg;
    logic signed [31:0] pb16_reg [0:2];
    logic signed [31:0] vb16_reg [0:2];
    logic        [62:0] mhi17_reg;
    logic        [62:0] mlo17_reg;
    logic signed [31:0] pb17_reg [0:2];
    logic signed [31:0] vb17_reg [0:2];

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            psq15_reg[i] <= vb14_reg[i] * vb14_reg[i];
        end
        pb15_reg  <= pb14_reg;
        vb15_reg  <= vb14_reg;
        v2_16_reg <= $unsigned(psq15_reg[0] >>> FRAC_BITS)
                   + $unsigned(psq15_reg[1] >>> FRAC_BITS)
                   + $unsigned(psq15_reg[2] >>> FRAC_BITS);
        pb16_reg  <= pb15_reg;
        vb16_reg  <= vb15_reg;
        mhi17_reg <= 63'(mass_dly) * 63'(v2_16_reg[63:32]);
        mlo17_reg <= 63'(mass_dly) * 63'(v2_16_reg[31:0]);
        pb17_reg  <= pb16_reg;
        vb17_reg  <= vb16_reg;
    end

    // stage 18: result registers
    logic [63:0]        ke_sum;
    logic [31:0]        ke18_next;
    logic signed [31:0] pout_reg [0:2];
    logic signed [31:0] vout_reg [0:2];
    logic [31:0]        ke_reg;

    always_comb
    begin
        ke_sum = (64'(mhi17_reg) << (31 - FRAC_BITS)) + (64'(mlo17_reg) >> (FRAC_BITS + 1));
        if (mhi17_reg >= 63'(64'd1 << (FRAC_BITS + 1)))
            ke18_next = '1;
        else if (ke_sum > 64'hFFFF_FFFF)
            ke18_next = '1;
        else
            ke18_next = ke_sum[31:0];
    end

    always_ff @(posedge clk)
    begin
        pout_reg <= pb17_reg;
        vout_reg <= vb17_reg;
        ke_reg   <= ke18_next;
    end

    assign new_pos_x      = pout_reg[0];
    assign new_pos_y      = pout_reg[1];
    assign new_pos_z      = pout_reg[2];
    assign new_vel_x      = vout_reg[0];
    assign new_vel_y      = vout_reg[1];
    assign new_vel_z      = vout_reg[2];
    assign kinetic_energy = ke_reg;

endmodule

// ===== hw/rtl/bpp_checker.sv =====
module bpp_checker
    import bpp_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               start,
    input logic               busy,
    input logic               done,
    input logic signed [31:0] new_vel_x,
    input logic signed [31:0] new_vel_y,
    input logic signed [31:0] new_vel_z,
    input logic        [31:0] kinetic_energy
);

    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
        else $error("busy raised");

    a_request_done: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##(PUSH_LAT + 1) done)
        else $error("request without result");

    a_done_request: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, PUSH_LAT + 1))
        else $error("result without request");

    a_still_no_energy: assert property (@(posedge clk) disable iff (!rst_n)
        (done && new_vel_x == 0 && new_vel_y == 0 && new_vel_z == 0)
            |-> kinetic_energy == 0)
        else $error("energy at rest");

endmodule

bind boris_particle_push_core bpp_checker u_bpp_checker (.*);

// ===== sim/boris_particle_push_core_tb.sv =====
`timescale 1ns / 1ps

module boris_particle_push_core_tb;
    import bpp_pkg::*;

    localparam logic [3:0] CFG_UNUSED = 4'd9;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam longint ONE = 64'sd65536;

    typedef struct {
        logic signed [31:0] pos [3];
        logic signed [31:0] vel [3];
        logic signed [31:0] chg;
        logic        [30:0] m;
        logic signed [31:0] force_in [3];
    } particle_t;

    typedef struct {
        logic signed [31:0] pos [3];
        logic signed [31:0] vel [3];
        logic        [31:0] energy;
    } pushed_t;

    class push_scoreboard;
        logic [1:0] mode;
        longint dt, b0, bx, bz, ey, ratio, dom;
        pushed_t pending [$];
        int errors;

        function new();
            mode = 0; dt = 655; b0 = 65536; bx = 0; bz = 65536;
            ey = 0; ratio = 196608; dom = 655360; errors = 0;
        endfunction

        function void write_reg(logic [3:0] idx, logic [31:0] d);
            case (idx)
                CFG_MODE:   mode  = d[1:0];
                CFG_DT:     dt    = longint'(d[30:0]);
                CFG_B0:     b0    = longint'($signed(d));
                CFG_BX:     bx    = longint'($signed(d));
                CFG_BZ:     bz    = longint'($signed(d));
                CFG_EY:     ey    = longint'($signed(d));
                CFG_RATIO:  ratio = longint'(d[30:0]);
                CFG_DOMAIN: dom   = longint'(d[30:0]);
                default: ;
            endcase
        endfunction

        function longint clip(longint x);
            if (x > 64'sd2147483647) return 64'sd2147483647;
            if (x < -64'sd2147483648) return -64'sd2147483648;
            return x;
        endfunction

        function longint fmul(longint a, longint b);
            return clip((a * b) >>> 16);
        endfunction

        function longint fdiv(longint n, longint d);
            if (d == 0)
                return n > 0 ? 64'sd2147483647 : (n < 0 ? -64'sd2147483648 : 0);
            return clip((n * ONE) / d);
        endfunction

        // one Boris step plus boundary rule and kinetic energy
        function void note(particle_t p);
            longint pp [3], v [3], b [3], t [3], s [3], vm [3], vp [3], kick [3];
            longint q, m, qmdt, t2, den, half, zn, mf;
            longint unsigned v2, hi, lo, mhi, ke;
            pushed_t r;
            q = longint'(p.chg);
            m = longint'(p.m);
            v2 = 0;
            for (int i = 0; i < 3; i++)
            begin
                pp[i] = longint'(p.pos[i]);
                v[i] = longint'(p.vel[i]);
            end
            qmdt = fmul(fdiv(q, m), dt) >>> 1;
            if (mode[0])
            begin
                zn = fdiv(2 * pp[2], dom);
                mf = clip(ONE + fmul(fmul(ratio - ONE, zn), zn));
                b[0] = 0; b[1] = 0; b[2] = fmul(b0, mf);
            end
            else
            begin
                b[0] = bx; b[1] = 0; b[2] = bz;
            end
            for (int i = 0; i < 3; i++)
            begin
                kick[i] = clip((i == 1 ? fmul(qmdt, ey) : 0)
                               + (fmul(fdiv(longint'(p.force_in[i]), m), dt) >>> 1));
                vm[i] = clip(v[i] + kick[i]);
                t[i] = fmul(qmdt, b[i]);
            end
            t2 = clip(fmul(t[0], t[0]) + fmul(t[1], t[1]) + fmul(t[2], t[2]));
            den = clip(ONE + t2);
            for (int i = 0; i < 3; i++)
                s[i] = fdiv(2 * t[i], den);
            vp[0] = clip(vm[0] + clip(fmul(vm[1], t[2]) - fmul(vm[2], t[1])));
            vp[1] = clip(vm[1] + clip(fmul(vm[2], t[0]) - fmul(vm[0], t[2])));
            vp[2] = clip(vm[2] + clip(fmul(vm[0], t[1]) - fmul(vm[1], t[0])));
            v[0] = clip(vm[0] + clip(fmul(vp[1], s[2]) - fmul(vp[2], s[1])));
            v[1] = clip(vm[1] + clip(fmul(vp[2], s[0]) - fmul(vp[0], s[2])));
            v[2] = clip(vm[2] + clip(fmul(vp[0], s[1]) - fmul(vp[1], s[0])));
            half = dom >>> 1;
            for (int i = 0; i < 3; i++)
            begin
                v[i] = clip(v[i] + kick[i]);
                pp[i] = clip(pp[i] + fmul(v[i], dt));
                if (mode[1])
                begin
                    if (pp[i] > half) pp[i] = clip(pp[i] - dom);
                    if (pp[i] < -half) pp[i] = clip(pp[i] + dom);
                end
                else
                begin
                    if (pp[i] > half)
                    begin
                        pp[i] = half; v[i] = clip(-v[i]);
                    end
                    if (pp[i] < -half)
                    begin
                        pp[i] = -half; v[i] = clip(-v[i]);
                    end
                end
                v2 += longint'((v[i] * v[i]) >>> 16);
                r.pos[i] = pp[i][31:0];
                r.vel[i] = v[i][31:0];
            end
            hi = v2 >> 32;
            lo = v2 & 64'hFFFF_FFFF;
            mhi = longint'(m) * hi;
            if (mhi >= (64'd1 << 17))
                ke = 64'hFFFF_FFFF;
            else
            begin
                ke = (mhi << 15) + ((longint'(m) * lo) >> 17);
                if (ke > 64'hFFFF_FFFF) ke = 64'hFFFF_FFFF;
            end
            r.energy = ke[31:0];
            pending = {pending, r};
        endfunction

        function void check(pushed_t a);
            pushed_t e;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected result", $time);
                errors++;
                return;
            end
            e = pending.pop_front();
            for (int i = 0; i < 3; i++)
            begin
                if (a.pos[i] !== e.pos[i])
                begin
                    $display("%0t: new_pos[%0d] expected %h actual %h", $time, i,
                             e.pos[i], a.pos[i]);
                    errors++;
                end
                if (a.vel[i] !== e.vel[i])
                begin
                    $display("%0t: new_vel[%0d] expected %h actual %h", $time, i,
                             e.vel[i], a.vel[i]);
                    errors++;
                end
            end
            if (a.energy !== e.energy)
            begin
                $display("%0t: kinetic_energy expected %h actual %h", $time,
                         e.energy, a.energy);
                errors++;
            end
        endfunction
    endclass

    logic clk = 0;
    logic rst_n = 1;
    logic start = 0;
    logic busy;
    logic cfg_wr_en = 0;
    logic [3:0] cfg_index = '0;
    logic [31:0] cfg_wdata = '0;
    logic signed [31:0] pos_x = 0, pos_y = 0, pos_z = 0;
    logic signed [31:0] vel_x = 0, vel_y = 0, vel_z = 0;
    logic signed [31:0] charge = 0;
    logic [30:0] mass = 0;
    logic signed [31:0] coulomb_fx = 0, coulomb_fy = 0, coulomb_fz = 0;
    logic done;
    logic signed [31:0] new_pos_x, new_pos_y, new_pos_z;
    logic signed [31:0] new_vel_x, new_vel_y, new_vel_z;
    logic [31:0] kinetic_energy;

    push_scoreboard sb = new();
    int idle_cycles = 0;

    boris_particle_push_core dut (.*);

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        pushed_t r;
        particle_t p;
        if (rst_n && start && !busy)
        begin
            p.pos = '{pos_x, pos_y, pos_z};
            p.vel = '{vel_x, vel_y, vel_z};
            p.chg = charge;
            p.m = mass;
            p.force_in = '{coulomb_fx, coulomb_fy, coulomb_fz};
            sb.note(p);
        end
        if (done)
        begin
            r.pos = '{new_pos_x, new_pos_y, new_pos_z};
            r.vel = '{new_vel_x, new_vel_y, new_vel_z};
            r.energy = kinetic_energy;
            sb.check(r);
        end
        if ((start && !busy) || done)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic int pick_gap();
        int k;
        k = $urandom_range(0, 99);
        if (k < 40) return 0;
        if (k < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic signed [31:0] rand_q(int scale);
        case ($urandom_range(0, 11))
            0: return 32'sh7FFF_FFFF;
            1: return 32'sh8000_0000;
            2: return 0;
            3, 4: return $urandom;
            default: return $signed($urandom_range(0, 2 * scale)) - scale;
        endcase
    endfunction

    function automatic particle_t rand_particle();
        particle_t p;
        bit noisy;
        noisy = ($urandom_range(0, 9) == 0);
        for (int i = 0; i < 3; i++)
        begin
            p.pos[i] = noisy ? $urandom : rand_q(6 * 65536);
            p.vel[i] = noisy ? $urandom : rand_q(20 * 65536);
            p.force_in[i] = ($urandom_range(0, 2) == 0) ? 0 : rand_q(4 * 65536);
        end
        p.chg = noisy ? $urandom : rand_q(2 * 65536);
        case ($urandom_range(0, 9))
            0: p.m = 31'($urandom);
            1: p.m = 0;
            2: p.m = 31'h7FFF_FFFF;
            default: p.m = 31'($urandom_range(16384, 8 * 65536));
        endcase
        return p;
    endfunction

    task automatic push_particle(particle_t p);
        int gap;
        start <= 1;
        {pos_x, pos_y, pos_z} <= {p.pos[0], p.pos[1], p.pos[2]};
        {vel_x, vel_y, vel_z} <= {p.vel[0], p.vel[1], p.vel[2]};
        charge <= p.chg;
        mass <= p.m;
        {coulomb_fx, coulomb_fy, coulomb_fz} <= {p.force_in[0], p.force_in[1],
                                                p.force_in[2]};
        @(posedge clk);
        while (busy)
            @(posedge clk);
        gap = pick_gap();
        if (gap > 0)
        begin
            start <= 0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // drain the pipe before touching registers
    task automatic wait_idle();
        start <= 0;
        @(posedge clk);
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (PUSH_LAT + 8) @(posedge clk);
    endtask

    task automatic write_reg(logic [3:0] idx, logic [31:0] d);
        cfg_wr_en <= 1;
        cfg_index <= idx;
        cfg_wdata <= d;
        @(posedge clk);
        sb.write_reg(idx, d);
        cfg_wr_en <= 0;
        @(posedge clk);
    endtask

    task automatic set_config(logic [1:0] mode, logic [31:0] dt, logic [31:0] b0,
                              logic [31:0] bx, logic [31:0] bz, logic [31:0] ey,
                              logic [31:0] ratio, logic [31:0] dom);
        write_reg(CFG_MODE, {$urandom} & ~32'h3 | mode);
        write_reg(CFG_DT, dt);
        write_reg(CFG_B0, b0);
        write_reg(CFG_BX, bx);
        write_reg(CFG_BZ, bz);
        write_reg(CFG_EY, ey);
        write_reg(CFG_RATIO, ratio);
        write_reg(CFG_DOMAIN, dom);
    endtask

    initial
    begin
        particle_t p;
        rst_n <= 0;
        repeat (8) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: defaults first, then extremes and special cases
        for (int k = 0; k < 20; k++)
        begin
            p = rand_particle();
            case (k)
                0: p.m = 0;
                1: begin p.m = 0; p.chg = 0; p.force_in = '{0, 0, 0}; end
                2: p.pos = '{32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF};
                3: p.pos = '{32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000};
                4: p.vel = '{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF};
                5: begin p.vel = '{32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000};
                         p.m = 31'h7FFF_FFFF; end
                6: begin p.chg = 32'sh7FFF_FFFF; p.m = 1; end
                7: begin p.chg = 32'sh8000_0000; p.m = 1; end
                8: p.force_in = '{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF};
                9: p.pos = '{32'sd327680, -32'sd327680, 32'sd327681};
                default: ;
            endcase
            push_particle(p);
        end
        wait_idle();
        write_reg(CFG_UNUSED, 32'hFFFF_FFFF);
        set_config(2'd3, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                   32'h8000_0000, 32'h7FFF_FFFF, 32'd1);
        for (int k = 0; k < 5; k++)
            push_particle(rand_particle());
        wait_idle();
        set_config(2'd1, 32'd0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                   32'h7FFF_FFFF, 32'd0, 32'h7FFF_FFFF);
        for (int k = 0; k < 5; k++)
            push_particle(rand_particle());

        // random phases, mostly physical settings with an occasional wild one
        for (int ph = 0; ph < 8; ph++)
        begin
            wait_idle();
            if (ph % 4 == 3)
                set_config(2'(ph), $urandom, $urandom, $urandom, $urandom, $urandom,
                           $urandom, $urandom);
            else
                set_config(2'(ph), $urandom_range(0, 16384),
                           rand_q(4 * 65536), rand_q(2 * 65536), rand_q(2 * 65536),
                           rand_q(2 * 65536), $urandom_range(0, 6 * 65536),
                           $urandom_range(1, 20 * 65536));
            for (int k = 0; k < 100; k++)
                push_particle(rand_particle());
        end

        wait_idle();
        if (sb.errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule
